>>> hdl/dvfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvfs_pkg
// Shared types and constants of the load-threshold DVFS governor.
// ----------------------------------------------------------------------------
package dvfs_pkg;

    localparam int unsigned FREQ_W = 22;
    localparam int unsigned TIME_W = 48;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned DWELL_W = 27;
    localparam int unsigned CFG_W  = 27;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned UP_FLOOR_FREQ_DEF = 998400;

    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_SUSPEND = 2'd1;
    localparam logic [1:0] OP_RESUME  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_CAP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PCT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL      = 3'd7;

    localparam logic [FREQ_W-1:0]  FREQ_MAX_RST   = 22'd1401600;
    localparam logic [FREQ_W-1:0]  FREQ_MIN_RST   = 22'd122880;
    localparam logic [FREQ_W-1:0]  SLEEP_CAP_RST  = 22'd245760;
    localparam logic [FREQ_W-1:0]  UP_STEP_RST    = 22'd100000;
    localparam logic [FREQ_W-1:0]  DOWN_LIMIT_RST = 22'd100000;
    localparam logic [PCT_W-1:0]   HIGH_PCT_RST   = 7'd60;
    localparam logic [PCT_W-1:0]   LOW_PCT_RST    = 7'd30;
    localparam logic [DWELL_W-1:0] DWELL_RST      = 27'd45000;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] wall_us;
        logic [TIME_W-1:0] idle_us;
        logic              no_idle_flag;
        logic [7:0]        tasks_running;
    } t_in_req;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_out;
        logic              request;
        logic              relation;
        logic [PCT_W-1:0]  load_pct;
    } t_out_res;

    typedef struct packed {
        logic capture;
        logic diff;
        logic busy;
        logic mul;
        logic div_step;
        logic quo;
        logic scale;
        logic pick;
        logic cap;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic eval_ok;
        logic delta_zero;
        logic load_low;
        logic div_last;
    } t_sts;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_DIFF  = 10'b00_0000_0010,
        ST_BUSY  = 10'b00_0000_0100,
        ST_MUL   = 10'b00_0000_1000,
        ST_DIV   = 10'b00_0001_0000,
        ST_QUO   = 10'b00_0010_0000,
        ST_SCALE = 10'b00_0100_0000,
        ST_PICK  = 10'b00_1000_0000,
        ST_CAP   = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } t_state;

endpackage

>>> hdl/dvfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvfs_ctrl
// Sequencer of the governor: steps one request through difference, load
// division, scale-down division, selection, capping and commit.
// ----------------------------------------------------------------------------
module dvfs_ctrl
    import dvfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_scale, n_scale;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_scale     = r_scale;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_scale       = 1'b0;
                    n_state       = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_BUSY;
            end
            ST_BUSY: begin
                o_cmd.busy = 1'b1;
                if (!i_sts.eval_ok) begin
                    n_state = ST_PICK;
                end else if (i_sts.delta_zero) begin
                    n_state = ST_QUO;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = r_scale ? ST_PICK : ST_QUO;
                end
            end
            ST_QUO: begin
                o_cmd.quo = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                if (i_sts.load_low) begin
                    o_cmd.scale = 1'b1;
                    n_scale     = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = ST_CAP;
            end
            ST_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scale     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scale     <= n_scale;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hdl/dvfs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvfs_dpath
// Datapath of the governor: configuration, frequency state, time
// differences, a shift-subtract divider for the load, a reciprocal
// multiplication for the scale-down and the output register.
// ----------------------------------------------------------------------------
module dvfs_dpath
    import dvfs_pkg::*;
#(
    parameter int unsigned UP_FLOOR_FREQ = UP_FLOOR_FREQ_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_req              i_in_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output t_out_res             o_out_data
);

    localparam int unsigned F1_W     = FREQ_W + 1;
    localparam int unsigned DIV_W    = TIME_W + PCT_W;
    localparam int unsigned QUO_W    = 24;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned PROD_W   = FREQ_W + 8;
    localparam int unsigned RECIP_W  = 2 * PROD_W;
    localparam int unsigned RECIP_SH = 36;
    localparam logic [F1_W-1:0]   FLOOR_FREQ = F1_W'(UP_FLOOR_FREQ);
    // The reciprocal of 100 rounded up at a scale of 2^36 is exact for any
    // dividend below 2^30.
    localparam logic [PROD_W-1:0] RECIP_100  = PROD_W'(687194768);
    localparam logic [CNT_W-1:0]  LOAD_ITER  = CNT_W'(PCT_W - 1);

    // Configuration.
    logic [FREQ_W-1:0]  r_fmax, r_fmin, r_cap, r_up_step, r_dlimit;
    logic [PCT_W-1:0]   r_high, r_low;
    logic [DWELL_W-1:0] r_dwell;

    // Governor state.
    logic [FREQ_W-1:0] r_cur;
    logic [TIME_W-1:0] r_chg_wall, r_chg_idle;
    logic              r_susp;

    // Working registers.
    t_in_req           r_in;
    logic [TIME_W-1:0] r_delta, r_itime, r_busy;
    logic              r_eval;
    logic [DIV_W-1:0]  r_rem, r_dsh;
    logic [QUO_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_recip;
    logic [PCT_W-1:0]  r_load;
    logic [7:0]        r_dummy;
    logic [FREQ_W-1:0] r_bound;
    logic              r_req, r_rel, r_noclamp;
    logic [F1_W-1:0]   r_nf1, r_nf2;
    t_out_res          r_out;

    logic [F1_W-1:0]    n_nf1, n_nf2;
    logic               n_req, n_rel, n_noclamp;
    logic [F1_W-1:0]    w_cur1, w_fmax1, w_fmin1, w_cap1, w_ramp, w_q, w_bound1;
    logic [F1_W-1:0]    w_low_nf, w_clip, w_clamp, w_final1;
    logic [FREQ_W-1:0]  w_final;
    logic               w_capped, w_ge, w_forced, w_evpath;
    logic [DIV_W-1:0]   w_busy100;
    logic [PROD_W-1:0]  w_prod;
    logic [RECIP_W-1:0] w_recip;
    logic [PCT_W-1:0]   w_load;
    logic [7:0]         w_sum;

    assign w_cur1   = {1'b0, r_cur};
    assign w_fmax1  = {1'b0, r_fmax};
    assign w_fmin1  = {1'b0, r_fmin};
    assign w_cap1   = {1'b0, r_cap};
    assign w_ramp   = (r_up_step == '0) ? w_fmax1 : w_cur1 + {1'b0, r_up_step};
    assign w_q      = r_quo[F1_W-1:0];
    assign w_bound1 = {1'b0, r_bound};
    assign w_low_nf = (r_dlimit != '0 && w_q < w_bound1) ? w_bound1 : w_q;
    assign w_capped = r_susp && (r_cap != '0);
    assign w_forced = (r_in.op == OP_SAMPLE) && r_in.no_idle_flag;
    assign w_evpath = (r_in.op == OP_SAMPLE) && !r_in.no_idle_flag;
    assign w_ge     = (r_rem >= r_dsh);
    assign w_busy100 = {1'b0, r_busy, 6'b0} + {2'b0, r_busy, 5'b0}
                     + {5'b0, r_busy, 2'b0};
    assign w_prod   = PROD_W'(r_cur) * PROD_W'(r_dummy);
    assign w_recip  = RECIP_W'(r_rem[PROD_W-1:0]) * RECIP_W'(RECIP_100);
    assign w_load   = o_sts.delta_zero ? PCT_W'(100) : r_quo[PCT_W-1:0];
    assign w_sum    = {1'b0, w_load} + 8'd100;

    assign w_clip   = (r_nf2 > w_fmax1) ? w_fmax1 : r_nf2;
    assign w_clamp  = (w_clip < w_fmin1) ? w_fmin1 : w_clip;
    assign w_final1 = r_noclamp ? r_nf2 : w_clamp;
    assign w_final  = w_final1[FREQ_W-1:0];

    assign o_sts.eval_ok    = w_evpath && (r_cur != r_fmin)
                            && (r_delta >= {{(TIME_W-DWELL_W){1'b0}}, r_dwell});
    assign o_sts.delta_zero = (r_delta == '0);
    assign o_sts.load_low   = (r_load < r_low);
    assign o_sts.div_last   = (r_cnt == '0);
    assign o_out_data       = r_out;

    always_comb begin
        n_req     = 1'b0;
        n_rel     = 1'b0;
        n_noclamp = 1'b0;
        n_nf1     = w_cur1;
        case (r_in.op)
            OP_SUSPEND: begin
                n_req = (r_cap != '0) && (r_cur > r_cap);
                n_rel = 1'b1;
                n_nf1 = w_cap1;
            end
            OP_RESUME: begin
                n_req     = (r_cap != '0);
                n_rel     = 1'b1;
                n_noclamp = 1'b1;
                n_nf1     = w_fmax1;
            end
            OP_SAMPLE: begin
                if (r_in.no_idle_flag) begin
                    n_req = (r_cur != r_fmax) && (r_in.tasks_running >= 8'd2);
                    n_nf1 = w_ramp;
                end else begin
                    n_req = r_eval;
                    if (r_load < r_low) begin
                        n_nf1 = w_low_nf;
                    end else if (r_load > r_high) begin
                        n_nf1 = w_ramp;
                    end else begin
                        n_nf1 = w_cur1;
                    end
                end
            end
            default: begin
                n_req = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_nf2 = r_nf1;
        if (w_forced) begin
            if (w_capped) begin
                n_nf2 = (r_nf1 > w_cap1) ? w_cap1 : r_nf1;
            end else begin
                n_nf2 = (r_nf1 < FLOOR_FREQ) ? FLOOR_FREQ : r_nf1;
            end
        end else if (w_evpath) begin
            if (w_capped && (r_nf1 > w_cap1 || r_nf1 > w_cur1)) begin
                n_nf2 = w_cap1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmax     <= FREQ_MAX_RST;
            r_fmin     <= FREQ_MIN_RST;
            r_cap      <= SLEEP_CAP_RST;
            r_up_step  <= UP_STEP_RST;
            r_dlimit   <= DOWN_LIMIT_RST;
            r_high     <= HIGH_PCT_RST;
            r_low      <= LOW_PCT_RST;
            r_dwell    <= DWELL_RST;
            r_cur      <= FREQ_MAX_RST;
            r_chg_wall <= '0;
            r_chg_idle <= '0;
            r_susp     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FREQ_MAX:   r_fmax    <= i_cfg_data[FREQ_W-1:0];
                    REG_FREQ_MIN:   r_fmin    <= i_cfg_data[FREQ_W-1:0];
                    REG_SLEEP_CAP:  r_cap     <= i_cfg_data[FREQ_W-1:0];
                    REG_UP_STEP:    r_up_step <= i_cfg_data[FREQ_W-1:0];
                    REG_DOWN_LIMIT: r_dlimit  <= i_cfg_data[FREQ_W-1:0];
                    REG_HIGH_PCT:   r_high    <= i_cfg_data[PCT_W-1:0];
                    REG_LOW_PCT:    r_low     <= i_cfg_data[PCT_W-1:0];
                    REG_DWELL:      r_dwell   <= i_cfg_data[DWELL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                if (r_req) begin
                    r_cur <= w_final;
                    if (r_in.op == OP_SAMPLE) begin
                        r_chg_wall <= r_in.wall_us;
                        r_chg_idle <= r_in.idle_us;
                    end
                end
                if (r_in.op == OP_SUSPEND) begin
                    r_susp <= 1'b1;
                end else if (r_in.op == OP_RESUME) begin
                    r_susp <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in   <= i_in_data;
            r_eval <= 1'b0;
            r_load <= '0;
        end
        if (i_cmd.diff) begin
            r_delta <= r_in.wall_us - r_chg_wall;
            r_itime <= r_in.idle_us - r_chg_idle;
        end
        if (i_cmd.busy) begin
            r_busy <= (r_itime > r_delta) ? '0 : r_delta - r_itime;
            r_eval <= o_sts.eval_ok;
        end
        if (i_cmd.mul) begin
            r_rem   <= w_busy100;
            r_dsh   <= {1'b0, r_delta, 6'b0};
            r_quo   <= '0;
            r_cnt   <= LOAD_ITER;
            r_recip <= 1'b0;
        end
        if (i_cmd.div_step) begin
            if (r_recip) begin
                r_quo <= w_recip[RECIP_SH +: QUO_W];
            end else begin
                r_rem <= w_ge ? r_rem - r_dsh : r_rem;
                r_dsh <= r_dsh >> 1;
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
            end
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.quo) begin
            r_load  <= w_load;
            r_dummy <= (w_sum > {1'b0, r_high}) ? w_sum - {1'b0, r_high} : 8'd0;
        end
        if (i_cmd.scale) begin
            r_rem   <= DIV_W'(w_prod);
            r_cnt   <= '0;
            r_recip <= 1'b1;
            r_bound <= (r_cur > r_dlimit) ? r_cur - r_dlimit : '0;
        end
        if (i_cmd.pick) begin
            r_req     <= n_req;
            r_rel     <= n_rel;
            r_noclamp <= n_noclamp;
            r_nf1     <= n_nf1;
        end
        if (i_cmd.cap) begin
            r_nf2 <= n_nf2;
        end
        if (i_cmd.commit) begin
            r_out.freq_out <= r_req ? w_final : r_cur;
            r_out.request  <= r_req;
            r_out.relation <= r_req & r_rel;
            r_out.load_pct <= r_req ? r_load : '0;
        end
    end

endmodule

>>> hdl/load_based_dvfs_governor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_based_dvfs_governor_core
// Load-threshold frequency governor for one core. Commands, ramp samples and
// samples that are not evaluated skip the load division; a sample that
// evaluates load runs its seven steps, and one that also scales down adds
// a reciprocal step. A zero time delta skips the division.
// A new request is taken in the cycle after the previous result is
// registered; a stalled result holds the next one back until it is taken.
// Synchronous active-low reset restores the configuration defaults and the
// frequency state, and leaves the output empty.
// ----------------------------------------------------------------------------
module load_based_dvfs_governor_core
    import dvfs_pkg::*;
#(
    parameter int unsigned UP_FLOOR_FREQ = UP_FLOOR_FREQ_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_req              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_res             o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    dvfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dvfs_dpath #(
        .UP_FLOOR_FREQ (UP_FLOOR_FREQ)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule
